@@ hdl/deq_pkg.sv @@
// deq_pkg: sizes, request and status codes, command struct for the deque
// used by every deque module except deq_ram; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int REQ_W  = 3;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int FILL_W = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;   // capture the request on this transfer
    logic exec;   // carry out the captured request
  } deq_cmd_t;

endpackage
`default_nettype wire

@@ hdl/double_ended_queue_top.sv @@
// channel    | ports                                   | handshake
// request    | in_req_type, in_push_value              | start high and busy low
// result     | out_read_value, out_status, out_fill_count | out_valid, one cycle
//
// a request passes through the execute state, which updates the ring and addresses the item RAM,
// then the output state, which holds the registered RAM read and shows the result
// busy is high only in the execute state, so a new request can be taken while a result is shown
// rst_n is synchronous; reset empties the queue, the RAM contents are left as they are
// the receiver cannot stall: every result is taken in its strobe cycle
//
// double_ended_queue_top: bounded deque of signed 32-bit items
// depends on deq_pkg, deq_ctrl, deq_dp
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [deq_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic signed [deq_pkg::VAL_W-1:0]    in_push_value,
  output logic                                     out_valid,
  output logic signed      [deq_pkg::VAL_W-1:0]    out_read_value,
  output logic             [deq_pkg::ST_W-1:0]     out_status,
  output logic             [deq_pkg::FILL_W-1:0]   out_fill_count
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req_type    (in_req_type),
    .in_push_value  (in_push_value),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

endmodule
`default_nettype wire

@@ hdl/deq_ram.sv @@
// deq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hdl/deq_ctrl.sv @@
// deq_ctrl: request sequencer of the deque (idle, execute, respond)
// depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none
module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output logic                   out_valid,
  output deq_pkg::deq_cmd_t      cmd
);
  import deq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  // a new request may be taken while the previous result is shown
  assign accept = start && (state_r != S_EXEC);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load  = accept;
  assign cmd.exec  = (state_r == S_EXEC);

endmodule
`default_nettype wire

@@ hdl/deq_dp.sv @@
// deq_dp: deque datapath: ring indices, fill count, item RAM, result fields
// depends on deq_pkg and deq_ram
`timescale 1ns / 1ps
`default_nettype none
module deq_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire deq_pkg::deq_cmd_t                   cmd,
  input  wire logic        [deq_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic signed [deq_pkg::VAL_W-1:0]    in_push_value,
  output logic signed      [deq_pkg::VAL_W-1:0]    out_read_value,
  output logic             [deq_pkg::ST_W-1:0]     out_status,
  output logic             [deq_pkg::FILL_W-1:0]   out_fill_count
);
  import deq_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [REQ_W-1:0] req_r;
  logic [VAL_W-1:0] val_r;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;
  logic             rd_sel_r, rd_sel_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic [VAL_W-1:0] rdata;
  logic             empty;
  logic             full;
  logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == CNT_FULL);
  assign front_inc = (front_r == IDX_LAST) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - 1'b1;
  assign back_inc  = (back_r == IDX_LAST) ? '0 : back_r + 1'b1;
  assign back_dec  = (back_r == '0) ? IDX_LAST : back_r - 1'b1;

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    cnt_nxt    = cnt_r;
    st_nxt     = ST_OK;
    rd_sel_nxt = 1'b0;
    we         = 1'b0;
    waddr      = back_r;
    raddr      = front_r;
    case (req_r)
      REQ_PUSH_FRONT: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          front_nxt = front_dec;
          waddr     = front_dec;
          we        = cmd.exec;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          back_nxt = back_inc;
          waddr    = back_r;
          we       = cmd.exec;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          raddr      = front_r;
          front_nxt  = front_inc;
          cnt_nxt    = cnt_r - 1'b1;
          rd_sel_nxt = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          raddr      = back_dec;
          back_nxt   = back_dec;
          cnt_nxt    = cnt_r - 1'b1;
          rd_sel_nxt = 1'b1;
        end
      end
      REQ_PEEK_FRONT: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          raddr      = front_r;
          rd_sel_nxt = 1'b1;
        end
      end
      REQ_PEEK_BACK: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          raddr      = back_dec;
          rd_sel_nxt = 1'b1;
        end
      end
      default: begin
        // unused codes leave the ring and fill count as they are
      end
    endcase
  end

  // request capture, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      val_r <= in_push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      back_r   <= '0;
      cnt_r    <= '0;
      st_r     <= ST_OK;
      rd_sel_r <= 1'b0;
    end else if (cmd.exec) begin
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      cnt_r    <= cnt_nxt;
      st_r     <= st_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
  end

  deq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_read_value = rd_sel_r ? rdata : '0;
  assign out_status     = st_r;
  assign out_fill_count = FILL_W'(cnt_r);

endmodule
`default_nettype wire

@@ hdl/deq_chk.sv @@
// deq_chk: port-level checks on the deque request and result channels
// depends on deq_pkg; bound to double_ended_queue_top
`timescale 1ns / 1ps
`default_nettype none
module deq_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                out_valid,
  input wire logic signed [deq_pkg::VAL_W-1:0]    out_read_value,
  input wire logic        [deq_pkg::ST_W-1:0]     out_status,
  input wire logic        [deq_pkg::FILL_W-1:0]   out_fill_count
);
  import deq_pkg::*;

  // every accepted request is followed by its result, with the execute state between
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing after request transfer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("busy not raised after request transfer");

  a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY || out_status == ST_FULL))
      |-> (out_read_value == '0))
    else $error("error result carries a value");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_FULL && out_fill_count <= FILL_W'(DEPTH)))
    else $error("bad status or fill count");

endmodule

bind double_ended_queue_top deq_chk u_deq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_read_value (out_read_value),
  .out_status     (out_status),
  .out_fill_count (out_fill_count)
);
`default_nettype wire

@@ sim/double_ended_queue_top_tb.sv @@
// double_ended_queue_top_tb: self-checking bench for the bounded deque, with an in-bench predictor
// depends on deq_pkg and double_ended_queue_top; checks every result field by field
`timescale 1ns / 1ps
module double_ended_queue_top_tb;
  import deq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
    logic [FILL_W-1:0]       fill_count;
  } deq_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [REQ_W-1:0]        in_req_type;
  logic signed [VAL_W-1:0] in_push_value;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_read_value;
  logic [ST_W-1:0]         out_status;
  logic [FILL_W-1:0]       out_fill_count;

  // predictor copy of the ring
  logic signed [VAL_W-1:0] ring_items [DEPTH];
  int                      ring_front;
  int                      ring_back;
  int                      ring_count;

  deq_result_t pending_results[$];
  int          error_count;
  int          cycle_count;

  double_ended_queue_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int ring_next(input int i);
    return (i == DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic int ring_prev(input int i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  // work out the answer to one accepted request and queue it
  task automatic predict_request(input logic [REQ_W-1:0] req, input logic signed [VAL_W-1:0] val);
    deq_result_t r;
    r.read_value = '0;
    r.status     = ST_OK;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (req == REQ_PUSH_FRONT) begin
          ring_front = ring_prev(ring_front);
          ring_items[ring_front] = val;
          ring_count++;
        end else begin
          ring_items[ring_back] = val;
          ring_back = ring_next(ring_back);
          ring_count++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          case (req)
            REQ_POP_FRONT: begin
              r.read_value = ring_items[ring_front];
              ring_front = ring_next(ring_front);
              ring_count--;
            end
            REQ_POP_BACK: begin
              ring_back = ring_prev(ring_back);
              r.read_value = ring_items[ring_back];
              ring_count--;
            end
            REQ_PEEK_FRONT: r.read_value = ring_items[ring_front];
            default: r.read_value = ring_items[ring_prev(ring_back)];
          endcase
        end
      end
      default: ;  // spare codes leave everything as it is
    endcase
    r.fill_count = ring_count[FILL_W-1:0];
    pending_results.push_back(r);
  endtask

  // called at a rising edge; returns at the edge of the transfer with start still high
  task automatic send_request(input logic [REQ_W-1:0] req, input logic signed [VAL_W-1:0] val);
    in_req_type   <= req;
    in_push_value <= val;
    start         <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_request(req, val);
  endtask

  task automatic idle_sender(input int n_cycles);
    start <= 1'b0;
    repeat (n_cycles) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [VAL_W-1:0] corner_value(input int k);
    case (k % 4)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic test_empty_queue();
    send_request(REQ_POP_FRONT, 32'sh5555_5555);
    send_request(REQ_POP_BACK, 32'shaaaa_aaaa);
    send_request(REQ_PEEK_FRONT, '0);
    send_request(REQ_PEEK_BACK, -32'sd1);
    send_request(REQ_SPARE_6, 32'sh1234_5678);
    send_request(REQ_SPARE_7, 32'sh7654_3210);
  endtask

  // alternate ends so the front index wraps, then knock on a full ring
  task automatic test_fill_to_full();
    logic signed [VAL_W-1:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      v = (i < 4) ? corner_value(i) : $signed($urandom);
      send_request(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, v);
    end
    send_request(REQ_PUSH_FRONT, 32'sh0bad_0001);
    send_request(REQ_PUSH_BACK, 32'sh0bad_0002);
    send_request(REQ_PEEK_FRONT, '0);
    send_request(REQ_PEEK_BACK, '0);
  endtask

  // segments lean towards pushing or popping so the ring swings between full and empty
  task automatic test_random_traffic(input int n_items, input bit with_gaps);
    int                      sent;
    int                      seg_left;
    int                      push_pct;
    bit                      gaps_on;
    logic [REQ_W-1:0]        req;
    logic signed [VAL_W-1:0] val;
    sent     = 0;
    seg_left = 0;
    push_pct = 50;
    gaps_on  = 1'b0;
    while (sent < n_items) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
        gaps_on = with_gaps && ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 99) < 4) begin
        req = $urandom_range(0, 1) ? REQ_SPARE_7 : REQ_SPARE_6;
      end else if ($urandom_range(0, 99) < push_pct) begin
        req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      end else begin
        case ($urandom_range(0, 5))
          0, 1: req = REQ_POP_FRONT;
          2, 3: req = REQ_POP_BACK;
          4: req = REQ_PEEK_FRONT;
          default: req = REQ_PEEK_BACK;
        endcase
      end
      val = ($urandom_range(0, 7) == 0) ? corner_value($urandom_range(0, 3)) : $signed($urandom);
      send_request(req, val);
      sent++;
      seg_left--;
      if (gaps_on && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 19));
    end
  endtask

  always @(negedge clk) begin : result_check
    deq_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: read_value %0d status %0d fill %0d",
                   out_read_value, out_status, out_fill_count);
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value || out_status !== want.status ||
            out_fill_count !== want.fill_count) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: read exp %0d got %0d, status exp %0d got %0d, fill exp %0d got %0d",
                     want.read_value, out_read_value, want.status, out_status,
                     want.fill_count, out_fill_count);
        end
      end
    end
  end

  initial begin
    error_count    = 0;
    cycle_count    = 0;
    ring_front     = 0;
    ring_back      = 0;
    ring_count     = 0;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_req_type   <= REQ_PUSH_FRONT;
    in_push_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_to_full();
    test_random_traffic(700, 1'b1);
    wait_results_drained();
    test_random_traffic(600, 1'b1);
    test_random_traffic(200, 1'b0);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
